>>> rtl/cawu_pkg.sv
// Shared types and CIGAR character codes for the CIGAR alignment walker.
package cawu_pkg;

    // CIGAR characters, ASCII.
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_MATCH = 8'h4D;  // 'M'
    localparam logic [7:0] CH_EQUAL = 8'h3D;  // '='
    localparam logic [7:0] CH_DIFF  = 8'h58;  // 'X'
    localparam logic [7:0] CH_INS   = 8'h49;  // 'I'
    localparam logic [7:0] CH_SOFT  = 8'h53;  // 'S'
    localparam logic [7:0] CH_DEL   = 8'h44;  // 'D'
    localparam logic [7:0] CH_SKIP  = 8'h4E;  // 'N'
    localparam logic [7:0] CH_HARD  = 8'h48;  // 'H'
    localparam logic [7:0] CH_PAD   = 8'h50;  // 'P'

    localparam logic [31:0] LEN_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0]  symbol;
        logic        first;
        logic        last;
        logic [30:0] map_pos;
        logic [30:0] window_start;
    } sym_t;

    typedef struct packed {
        logic        seg_valid;
        logic [31:0] seg_window_index;
        logic [31:0] seg_read_index;
        logic [31:0] seg_length;
        logic        done_res;
        logic [31:0] end_pos;
        logic        bad_op;
    } res_t;

    // Walker state. win_cur is the window-relative reference cursor and
    // end_base the 0-based last reference position covered so far, both
    // kept running so that no result needs more than one add.
    typedef struct packed {
        logic [31:0] op_len;
        logic [31:0] win_cur;
        logic [31:0] end_base;
        logic [31:0] read_cur;
        logic        aborted;
    } walk_state_t;

endpackage

>>> rtl/cawu_step.sv
// Combinational step of the CIGAR walker: one character in, next state and result out.
module cawu_step (
    input  cawu_pkg::sym_t        item,
    input  cawu_pkg::walk_state_t state,
    output cawu_pkg::walk_state_t state_next,
    output cawu_pkg::res_t        result
);
    import cawu_pkg::*;

    walk_state_t base;
    logic [35:0] prod;
    logic        is_digit;

    // A first character restarts the record from the sampled positions.
    always_comb
    begin
        if (item.first)
        begin
            base.op_len   = '0;
            base.win_cur  = {1'b0, item.map_pos} + ~{1'b0, item.window_start};
            base.end_base = {1'b0, item.map_pos} - 32'd2;
            base.read_cur = '0;
            base.aborted  = 1'b0;
        end
        else
        begin
            base = state;
        end
    end

    assign is_digit = item.symbol inside {[CH_ZERO:CH_NINE]};
    assign prod     = ({4'b0, base.op_len} << 3) + ({4'b0, base.op_len} << 1)
                    + {32'b0, item.symbol[3:0]};

    always_comb
    begin
        state_next = base;
        result     = '0;
        if (!base.aborted)
        begin
            if (is_digit)
            begin
                state_next.op_len = (prod[35:32] != 4'b0) ? LEN_MAX : prod[31:0];
            end
            else
            begin
                state_next.op_len = '0;
                case (item.symbol)
                    CH_MATCH, CH_EQUAL, CH_DIFF:
                    begin
                        result.seg_valid        = 1'b1;
                        result.seg_window_index = base.win_cur;
                        result.seg_read_index   = base.read_cur;
                        result.seg_length       = base.op_len;
                        state_next.win_cur      = base.win_cur + base.op_len;
                        state_next.end_base     = base.end_base + base.op_len;
                        state_next.read_cur     = base.read_cur + base.op_len;
                    end
                    CH_INS, CH_SOFT:
                    begin
                        state_next.read_cur = base.read_cur + base.op_len;
                    end
                    CH_DEL, CH_SKIP:
                    begin
                        state_next.win_cur  = base.win_cur + base.op_len;
                        state_next.end_base = base.end_base + base.op_len;
                    end
                    CH_HARD, CH_PAD:
                    begin
                    end
                    default:
                    begin
                        state_next.aborted = 1'b1;
                    end
                endcase
            end
        end
        result.done_res = item.last;
        result.bad_op   = state_next.aborted;
        result.end_pos  = (item.last && !state_next.aborted) ? state_next.end_base : '0;
    end

endmodule

>>> rtl/cigar_alignment_walker_unit.sv
// Top level of the CIGAR alignment walker: input register, step logic, result register.
//
// The walker takes one SAM CIGAR character per transfer on the sym channel and
// gives exactly one result per character on the res channel. A character
// flagged first samples the 1-based mapping position and the window start and
// restarts every cursor; digits build an operation length that saturates at
// 2^32-1; M, = and X report a match segment (window-relative reference index,
// read index, length); I and S move the read cursor, D and N the reference
// cursor, H and P change nothing, and any other character aborts the record
// until the next first. On a character flagged last the result carries the
// 0-based last reference position covered (zero if the record was aborted).
// All positions wrap modulo 2^32. Throughput is one character per cycle
// without stalls: the whole step is one pass of combinational logic between
// the input register and the result register, and the walker state is updated
// as a character moves from one to the other. An accepted character waits in
// the input register until the result register can take it, and its result
// is driven on the res channel from the result register. The input
// register takes a new transfer whenever it is empty or its content moves on
// in the same cycle, so it keeps filling while a finished result still waits
// to be taken.
module cigar_alignment_walker_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            sym_valid,
    output logic            sym_ready,
    input  cawu_pkg::sym_t  sym_data,
    output logic            res_valid,
    input  logic            res_ready,
    output cawu_pkg::res_t  res_data
);
    import cawu_pkg::*;

    logic        in_valid_reg;
    sym_t        in_data_reg;
    logic        out_valid_reg;
    res_t        out_data_reg;
    walk_state_t state_reg;
    walk_state_t state_next;
    res_t        step_result;
    logic        advance;

    // The held character moves into the result register when that register
    // is empty or its result is taken in this cycle.
    assign advance   = in_valid_reg && (!out_valid_reg || res_ready);
    assign sym_ready = !in_valid_reg || advance;

    cawu_step u_step (
        .item       (in_data_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    // Control and walker state. After reset the reference cursor stands at
    // zero, so the last covered position reads as all ones.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            state_reg.op_len   <= '0;
            state_reg.win_cur  <= '0;
            state_reg.end_base <= '1;
            state_reg.read_cur <= '0;
            state_reg.aborted  <= 1'b0;
        end
        else
        begin
            if (sym_ready)
            begin
                in_valid_reg <= sym_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (sym_ready && sym_valid)
        begin
            in_data_reg <= sym_data;
        end
        if (advance)
        begin
            out_data_reg <= step_result;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

endmodule

>>> sim/cawu_walk_checker.sv
// Checker for the CIGAR alignment walker: predicts each result and compares transfers.
`timescale 1ns / 100ps

module cawu_walk_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            sym_valid,
    input  logic            sym_ready,
    input  cawu_pkg::sym_t  sym_data,
    input  logic            res_valid,
    input  logic            res_ready,
    input  cawu_pkg::res_t  res_data,
    output int              fail_count,
    output int              pending,
    output int              checked,
    output int              segments,
    output int              record_ends,
    output int              aborted_ends
);
    import cawu_pkg::*;

    // Walker state as the predictor sees it.
    logic [31:0] len_acc;
    logic [31:0] rec_base;
    logic [31:0] win_off;
    logic [31:0] ref_used;
    logic [31:0] read_used;
    logic        killed;

    res_t due_q[$];

    // Advances the predicted walker by one character and returns its result.
    function automatic res_t walk_char(input sym_t c);
        res_t        r;
        logic [35:0] grown;
        r = '0;
        if (c.first) begin
            rec_base  = {1'b0, c.map_pos} - 32'd1;
            win_off   = rec_base - {1'b0, c.window_start};
            len_acc   = '0;
            ref_used  = '0;
            read_used = '0;
            killed    = 1'b0;
        end
        if (!killed) begin
            if (c.symbol >= CH_ZERO && c.symbol <= CH_NINE) begin
                grown   = {4'b0, len_acc} * 36'd10 + {28'b0, c.symbol - CH_ZERO};
                len_acc = (grown > {4'b0, LEN_MAX}) ? LEN_MAX : grown[31:0];
            end
            else begin
                case (c.symbol)
                    CH_MATCH, CH_EQUAL, CH_DIFF:
                    begin
                        r.seg_valid        = 1'b1;
                        r.seg_window_index = win_off + ref_used;
                        r.seg_read_index   = read_used;
                        r.seg_length       = len_acc;
                        ref_used           = ref_used + len_acc;
                        read_used          = read_used + len_acc;
                    end
                    CH_INS, CH_SOFT:
                    begin
                        read_used = read_used + len_acc;
                    end
                    CH_DEL, CH_SKIP:
                    begin
                        ref_used = ref_used + len_acc;
                    end
                    CH_HARD, CH_PAD:
                    begin
                    end
                    default:
                    begin
                        killed = 1'b1;
                    end
                endcase
                len_acc = '0;
            end
        end
        r.done_res = c.last;
        r.end_pos  = (c.last && !killed) ? rec_base + ref_used - 32'd1 : '0;
        r.bad_op   = killed;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n) begin
            len_acc   = '0;
            rec_base  = '0;
            win_off   = '0;
            ref_used  = '0;
            read_used = '0;
            killed    = 1'b0;
            due_q.delete();
        end
        else begin
            // The result side is handled first; the walker's latency keeps a
            // character accepted at this edge from being due at the same edge.
            if (res_valid && res_ready) begin
                if (due_q.size() == 0) begin
                    $display("%0t: result transfer with nothing expected, actual %h",
                             $time, res_data);
                    fail_count++;
                end
                else begin
                    want = due_q.pop_front();
                    check_field("seg_valid", {31'b0, want.seg_valid},
                                {31'b0, res_data.seg_valid});
                    check_field("seg_window_index", want.seg_window_index,
                                res_data.seg_window_index);
                    check_field("seg_read_index", want.seg_read_index,
                                res_data.seg_read_index);
                    check_field("seg_length", want.seg_length, res_data.seg_length);
                    check_field("done_res", {31'b0, want.done_res},
                                {31'b0, res_data.done_res});
                    check_field("end_pos", want.end_pos, res_data.end_pos);
                    check_field("bad_op", {31'b0, want.bad_op},
                                {31'b0, res_data.bad_op});
                    checked++;
                    if (want.seg_valid)
                        segments++;
                    if (want.done_res)
                        record_ends++;
                    if (want.done_res && want.bad_op)
                        aborted_ends++;
                end
            end
            if (sym_valid && sym_ready)
                due_q.push_back(walk_char(sym_data));
        end
        pending = due_q.size();
    end

endmodule

>>> sim/tb_top.sv
// Top of the CIGAR alignment walker testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
    import cawu_pkg::*;

    logic clk = 1'b0;
    logic rst_n;
    logic sym_valid;
    logic sym_ready;
    sym_t sym_data;
    logic res_valid;
    logic res_ready;
    res_t res_data;

    int fail_count;
    int pending;
    int checked;
    int segments;
    int record_ends;
    int aborted_ends;

    // Characters accepted so far. It steers the quiet stretch and the long
    // receiver hold-off, and tells the stimulus when to stop.
    int items_sent = 0;
    int hold_left  = 0;
    bit held_once  = 1'b0;

    cigar_alignment_walker_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_valid (sym_valid),
        .sym_ready (sym_ready),
        .sym_data  (sym_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    cawu_walk_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .sym_valid    (sym_valid),
        .sym_ready    (sym_ready),
        .sym_data     (sym_data),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res_data     (res_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked      (checked),
        .segments     (segments),
        .record_ends  (record_ends),
        .aborted_ends (aborted_ends)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Both sides pause at random, with a chance of 31 in a hundred, except during a
    // stretch in the middle of the run where transfers go back to back.
    function automatic bit take_break();
        if (items_sent >= 300 && items_sent < 420)
            return 1'b0;
        return $urandom_range(0, 99) < 31;
    endfunction

    // Positions are mostly random over the whole 31-bit field, with zero
    // (which wraps the record start), one and the all-ones value mixed in.
    function automatic logic [30:0] pick_pos();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return 31'd1;
            default: return 31'($urandom);
        endcase
    endfunction

    // Match operations are weighted up, since they are the ones that report.
    function automatic logic [7:0] pick_op();
        case ($urandom_range(0, 11))
            0: return CH_EQUAL;
            1: return CH_DIFF;
            2: return CH_INS;
            3: return CH_SOFT;
            4: return CH_DEL;
            5: return CH_SKIP;
            6: return CH_HARD;
            7: return CH_PAD;
            default: return CH_MATCH;
        endcase
    endfunction

    // A single character with neither flag set. Positions on characters
    // other than the first are random, as the walker must ignore them.
    function automatic sym_t glyph(input logic [7:0] s);
        sym_t c;
        c              = '0;
        c.symbol       = s;
        c.map_pos      = 31'($urandom);
        c.window_start = 31'($urandom);
        return c;
    endfunction

    // Offers one character and returns at the falling edge after its transfer.
    // It must be called at a falling edge; valid stays high into the next call.
    task automatic send_sym(input sym_t s);
        while (take_break()) begin
            sym_valid <= 1'b0;
            @(negedge clk);
        end
        sym_valid <= 1'b1;
        sym_data  <= s;
        do
            @(posedge clk);
        while (!sym_ready);
        items_sent++;
        @(negedge clk);
    endtask

    // Sends a whole CIGAR string as one record, first on its opening
    // character and last on its final one.
    task automatic send_text(input string txt, input logic [30:0] mp,
                             input logic [30:0] ws);
        sym_t c;
        for (int i = 0; i < txt.len(); i++) begin
            c = glyph(txt[i]);
            if (i == 0) begin
                c.first        = 1'b1;
                c.map_pos      = mp;
                c.window_start = ws;
            end
            c.last = (i == txt.len() - 1);
            send_sym(c);
        end
    endtask

    // A random record. Most are well formed: short decimal lengths, now and
    // then none at all or one long enough to saturate. A broken record may
    // carry an arbitrary byte where an operation should be. Some records
    // leave out the first flag and so continue the previous one, some raise
    // last early, and some end on trailing digits.
    task automatic walk_record(input bit broken);
        sym_t line[$];
        int   n_ops;
        int   n_dig;
        n_ops = $urandom_range(1, 6);
        for (int k = 0; k < n_ops; k++) begin
            case ($urandom_range(0, 19))
                0: n_dig = 0;
                1: n_dig = $urandom_range(9, 11);
                default: n_dig = $urandom_range(1, 2);
            endcase
            for (int d = 0; d < n_dig; d++)
                line.push_back(glyph(CH_ZERO + 8'($urandom_range(0, 9))));
            if (broken && $urandom_range(0, 3) == 0)
                line.push_back(glyph(8'($urandom_range(0, 255))));
            else
                line.push_back(glyph(pick_op()));
        end
        if ($urandom_range(0, 6) == 0)
            line.push_back(glyph(CH_ZERO + 8'($urandom_range(0, 9))));
        foreach (line[i])
            line[i].last = ($urandom_range(0, 19) == 0);
        line[line.size() - 1].last = 1'b1;
        if ($urandom_range(0, 9) != 0) begin
            line[0].first        = 1'b1;
            line[0].map_pos      = pick_pos();
            line[0].window_start = pick_pos();
        end
        foreach (line[i])
            send_sym(line[i]);
    endtask

    // Plain noise: arbitrary bytes with both flags raised at random.
    task automatic send_noise();
        sym_t c;
        int   n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            c              = glyph(8'($urandom_range(0, 255)));
            c.first        = ($urandom_range(0, 4) == 0);
            c.last         = ($urandom_range(0, 4) == 0);
            c.map_pos      = pick_pos();
            c.window_start = pick_pos();
            send_sym(c);
        end
    endtask

    // Result side. Once, well into the run, the receiver holds off for a long
    // stretch while the sender keeps offering, so that the walker's registers
    // fill and its input stalls.
    always @(negedge clk)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else if (hold_left > 0) begin
            res_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!held_once && items_sent >= 500) begin
            held_once <= 1'b1;
            hold_left <= 80;
            res_ready <= 1'b0;
        end
        else
            res_ready <= !take_break();
    end

    initial
    begin
        rst_n     = 1'b0;
        sym_valid = 1'b0;
        sym_data  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. The first record starts at mapping position zero, so
        // the record start wraps, uses every operation with and without a
        // length, and ends on a trailing digit. The second builds a length
        // past 2^32-1, which must saturate. The third opens with an invalid
        // character, after which the rest of the record is ignored.
        send_text("5MI2DNS=XHP9", 31'd0, 31'h7FFF_FFFF);
        send_text("5555555555M", 31'h7FFF_FFFF, 31'd0);
        send_text("#3M", 31'd100, 31'd40);

        while (items_sent < 750) begin
            case ($urandom_range(0, 9))
                0: send_noise();
                1: walk_record(1'b1);
                default: walk_record(1'b0);
            endcase
        end
        sym_valid <= 1'b0;

        // Drain: wait for every expected result, then keep watching for a while so
        // that a stray extra result would still be caught.
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("Run covered %0d characters and %0d checked results: %0d match segments,",
                 items_sent, checked, segments);
        $display("%0d record ends, %0d of them on aborted records.",
                 record_ends, aborted_ends);
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #2000000;
        $display("tb_top failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/cawu_pkg.sv
rtl/cawu_step.sv
rtl/cigar_alignment_walker_unit.sv
sim/cawu_walk_checker.sv
sim/tb_top.sv
